>>> design/pdrp_pkg.sv
package pdrp_pkg;

    // Widths of the character and of the parsed value.
    localparam int unsigned ChW     = 8;
    localparam int unsigned ValueW  = 64;
    localparam int unsigned CountW  = 4;
    localparam int unsigned StatusW = 3;

    // Longest prefix the block compares.
    localparam logic [CountW-1:0] PrefixMax = 4'd8;

    // Configuration register indexes.
    typedef enum logic {
        REG_PREFIX_CHARS  = 1'b0,
        REG_PREFIX_LENGTH = 1'b1
    } t_reg_index;

    // Reply status codes.
    typedef enum logic [StatusW-1:0] {
        ST_OK     = 3'd0,
        ST_PREFIX = 3'd1,
        ST_NOTINT = 3'd2,
        ST_RANGE  = 3'd3,
        ST_TRAIL  = 3'd4
    } t_status;

    // Character codes of interest.
    localparam logic [ChW-1:0] ChMinus = 8'h2D;
    localparam logic [ChW-1:0] ChZero  = 8'h30;
    localparam logic [ChW-1:0] ChNine  = 8'h39;

    // Largest magnitude that may still take one more digit: floor((2^63-1)/10),
    // which equals floor(2^63/10). The last digit limit is 7, or 8 with a sign.
    localparam logic [ValueW-1:0] MagStepMax = 64'd922337203685477580;
    localparam logic [3:0]        LastDigitPos = 4'd7;
    localparam logic [3:0]        LastDigitNeg = 4'd8;

    // Saturation point of the character counter.
    localparam logic [CountW-1:0] CountMax = 4'd15;

endpackage

>>> design/prefixed_decimal_reply_parser.sv
// Prefixed decimal reply parser.
// A reply streams in one character per transfer on the slave side (tdata holds
// the character, tlast marks the final character). The reply must begin with
// the configured prefix and be longer than it; after the prefix comes an
// optional '-' and decimal digits, accumulated into a signed 64-bit value.
// For each final character one result transfer leaves on the master side:
// tuser holds the status, tdata the value (zero unless the status is ok).
// Characters without tlast produce no result.
// The prefix is set through the write port (index 0: prefix characters, first
// in the lowest byte; index 1: prefix length, values above eight act as eight);
// the user must set it only while the block is idle; the block does not enforce this.
// Throughput is one character per cycle, set by the single multiply-by-ten and
// accumulate step between the input register and the result register, unless a
// final character stalls. A final character's result goes to the result register.
// When the receiver stalls, the result is held and characters keep flowing in
// until a second final character must wait in the input register.
// Reset clears the prefix registers, the per-reply state and both valid flags.
module prefixed_decimal_reply_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [pdrp_pkg::ValueW-1:0]    i_cfg_data,
    // Character stream.
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [pdrp_pkg::ChW-1:0]       i_s_axis_tdata,   // [7:0] ch
    input  logic                           i_s_axis_tlast,
    // Result stream.
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [pdrp_pkg::ValueW-1:0]    o_m_axis_tdata,   // [63:0] value
    output logic [pdrp_pkg::StatusW-1:0]   o_m_axis_tuser    // [2:0] status
);

    // Configuration registers.
    logic [pdrp_pkg::ValueW-1:0] r_prefix_chars;
    logic [pdrp_pkg::CountW-1:0] r_prefix_length;

    // Input register.
    logic                        r_in_valid;
    logic [pdrp_pkg::ChW-1:0]    r_in_ch;
    logic                        r_in_last;

    // Per-reply state.
    logic [pdrp_pkg::CountW-1:0] r_count,      n_count;
    logic                        r_mismatch,   n_mismatch;
    logic                        r_minus,      n_minus;
    logic                        r_have_digit, n_have_digit;
    logic                        r_stopped,    n_stopped;
    logic                        r_overflow,   n_overflow;
    logic [pdrp_pkg::ValueW-1:0] r_mag,        n_mag;

    // Result register.
    logic                        r_out_valid;
    logic [pdrp_pkg::ValueW-1:0] r_out_value;
    pdrp_pkg::t_status           r_out_status;

    logic                        stall;
    logic                        proc;
    logic [pdrp_pkg::CountW-1:0] plen;
    logic                        in_prefix;
    logic [pdrp_pkg::ChW-1:0]    want;
    logic                        is_digit;
    logic [3:0]                  digit;
    logic [3:0]                  digit_max;
    logic [pdrp_pkg::ValueW-1:0] mag_step;
    pdrp_pkg::t_status           status;
    logic [pdrp_pkg::ValueW-1:0] value;

    // A final character waits while the result register is still occupied.
    assign stall           = r_in_valid && r_in_last && r_out_valid && !i_m_axis_tready;
    assign proc            = r_in_valid && !stall;
    assign o_s_axis_tready = !r_in_valid || !stall;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = r_out_status;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_chars  <= '0;
            r_prefix_length <= '0;
        end else if (i_cfg_we) begin
            unique case (pdrp_pkg::t_reg_index'(i_cfg_index))
                pdrp_pkg::REG_PREFIX_CHARS:  r_prefix_chars  <= i_cfg_data;
                pdrp_pkg::REG_PREFIX_LENGTH: r_prefix_length <= i_cfg_data[pdrp_pkg::CountW-1:0];
                default: ;
            endcase
        end
    end

    // Input register takes a character whenever it is free or moving on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_ch   <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // Character classification and prefix compare.
    always_comb begin
        plen      = (r_prefix_length > pdrp_pkg::PrefixMax) ? pdrp_pkg::PrefixMax
                                                            : r_prefix_length;
        in_prefix = r_count < plen;
        want      = r_prefix_chars[{r_count[2:0], 3'b000} +: pdrp_pkg::ChW];
        is_digit  = (r_in_ch >= pdrp_pkg::ChZero) && (r_in_ch <= pdrp_pkg::ChNine);
        digit     = 4'(r_in_ch - pdrp_pkg::ChZero);
        digit_max = r_minus ? pdrp_pkg::LastDigitNeg : pdrp_pkg::LastDigitPos;
        mag_step  = (r_mag << 3) + (r_mag << 1) + {60'd0, digit};
    end

    // Next per-reply state for the character in the input register.
    always_comb begin
        n_count      = (r_count < pdrp_pkg::CountMax) ? r_count + 4'd1 : r_count;
        n_mismatch   = r_mismatch;
        n_minus      = r_minus;
        n_have_digit = r_have_digit;
        n_stopped    = r_stopped;
        n_overflow   = r_overflow;
        n_mag        = r_mag;
        priority if (in_prefix) begin
            if (want != r_in_ch) begin
                n_mismatch = 1'b1;
            end
        end else if (r_stopped) begin
            // Number already ended; the rest is ignored.
        end else if ((r_count == plen) && (r_in_ch == pdrp_pkg::ChMinus)) begin
            n_minus = 1'b1;
        end else if (!is_digit) begin
            n_stopped = 1'b1;
        end else begin
            n_have_digit = 1'b1;
            if (!r_overflow) begin
                if ((r_mag > pdrp_pkg::MagStepMax) ||
                    ((r_mag == pdrp_pkg::MagStepMax) && (digit > digit_max))) begin
                    n_overflow = 1'b1;
                end else begin
                    n_mag = mag_step;
                end
            end
        end
    end

    // Status of the reply ending with this character, checks in rank order.
    always_comb begin
        value = '0;
        priority if (n_mismatch || in_prefix) begin
            status = pdrp_pkg::ST_PREFIX;
        end else if (!n_have_digit) begin
            status = pdrp_pkg::ST_NOTINT;
        end else if (n_overflow) begin
            status = pdrp_pkg::ST_RANGE;
        end else if (n_stopped) begin
            status = pdrp_pkg::ST_TRAIL;
        end else begin
            status = pdrp_pkg::ST_OK;
            value  = n_minus ? (~n_mag + 64'd1) : n_mag;
        end
    end

    // Per-reply state update; a final character clears it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_mismatch   <= 1'b0;
            r_minus      <= 1'b0;
            r_have_digit <= 1'b0;
            r_stopped    <= 1'b0;
            r_overflow   <= 1'b0;
            r_mag        <= '0;
        end else if (proc) begin
            if (r_in_last) begin
                r_count      <= '0;
                r_mismatch   <= 1'b0;
                r_minus      <= 1'b0;
                r_have_digit <= 1'b0;
                r_stopped    <= 1'b0;
                r_overflow   <= 1'b0;
                r_mag        <= '0;
            end else begin
                r_count      <= n_count;
                r_mismatch   <= n_mismatch;
                r_minus      <= n_minus;
                r_have_digit <= n_have_digit;
                r_stopped    <= n_stopped;
                r_overflow   <= n_overflow;
                r_mag        <= n_mag;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_in_last) begin
            r_out_status <= status;
            r_out_value  <= value;
        end
    end

endmodule

>>> tb/sv/prefixed_decimal_reply_parser_tb.sv
module prefixed_decimal_reply_parser_tb;

    // Local copies of the package widths, used in size casts.
    localparam int ChW     = pdrp_pkg::ChW;
    localparam int ValueW  = pdrp_pkg::ValueW;
    localparam int CountW  = pdrp_pkg::CountW;
    localparam int StatusW = pdrp_pkg::StatusW;

    // Cycles without any transfer before the run is abandoned.
    localparam int QuietLimit = 2000;
    // Characters of random replies in each random phase.
    localparam int PhaseChars = 125;
    localparam int RandomPhases = 8;

    typedef struct {
        logic [ChW-1:0] ch;
        logic           last;
    } t_char_item;

    typedef struct {
        pdrp_pkg::t_status status;
        logic [ValueW-1:0] value;
    } t_reply_result;

    logic                 i_clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    pdrp_pkg::t_reg_index cfg_index = pdrp_pkg::REG_PREFIX_CHARS;
    logic [ValueW-1:0]    cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [ChW-1:0]       s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [ValueW-1:0]    m_tdata;
    logic [StatusW-1:0]   m_tuser;

    // Characters waiting to be sent and replies waiting to come back.
    t_char_item           char_queue[$];
    t_reply_result        parsed_replies[$];
    logic [ChW-1:0]       reply_buf[$];
    t_char_item           next_char;
    t_reply_result        got_reply;

    // Predictor copy of the configuration and of the per-reply state.
    logic [ValueW-1:0]    pfx_chars = '0;
    logic [CountW-1:0]    pfx_len = '0;
    logic [CountW-1:0]    seen_cnt = '0;
    logic                 pfx_bad = 1'b0;
    logic                 neg_sign = 1'b0;
    logic                 got_digit = 1'b0;
    logic                 num_done = 1'b0;
    logic                 too_big = 1'b0;
    logic [ValueW-1:0]    mag_acc = '0;

    logic                 calm = 1'b0;
    int                   failures = 0;
    int                   quiet = 0;
    int                   gen_count;

    prefixed_decimal_reply_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [7:0] ch
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // [63:0] value
        .o_m_axis_tuser  (m_tuser)    // [2:0] status
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int eff_pfx_len();
        return (pfx_len > pdrp_pkg::PrefixMax) ? int'(pdrp_pkg::PrefixMax) : int'(pfx_len);
    endfunction

    // Advance the predicted parse by one accepted character; a final character
    // yields the expected reply result and clears the per-reply state.
    task automatic parse_reply_char(input logic [ChW-1:0] ch, input logic last);
        int                pos;
        int                plen;
        logic [ValueW-1:0] lim;
        logic [ValueW-1:0] digit;
        t_reply_result     res;
        pos = int'(seen_cnt);
        plen = eff_pfx_len();
        if (pos < plen) begin
            if (pfx_chars[pos*8 +: 8] != ch) pfx_bad = 1'b1;
        end else if (!num_done) begin
            if (pos == plen && ch == pdrp_pkg::ChMinus) begin
                neg_sign = 1'b1;
            end else if (ch < pdrp_pkg::ChZero || ch > pdrp_pkg::ChNine) begin
                num_done = 1'b1;
            end else begin
                got_digit = 1'b1;
                if (!too_big) begin
                    lim = neg_sign ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                    digit = ValueW'(ch - pdrp_pkg::ChZero);
                    if (mag_acc > lim / 10 || (mag_acc == lim / 10 && digit > lim % 10))
                        too_big = 1'b1;
                    else
                        mag_acc = mag_acc * 10 + digit;
                end
            end
        end
        if (seen_cnt != pdrp_pkg::CountMax) seen_cnt = seen_cnt + 1'b1;
        if (last) begin
            res.value = '0;
            if (pfx_bad || pos < plen) begin
                res.status = pdrp_pkg::ST_PREFIX;
            end else if (!got_digit) begin
                res.status = pdrp_pkg::ST_NOTINT;
            end else if (too_big) begin
                res.status = pdrp_pkg::ST_RANGE;
            end else if (num_done) begin
                res.status = pdrp_pkg::ST_TRAIL;
            end else begin
                res.status = pdrp_pkg::ST_OK;
                res.value = neg_sign ? -mag_acc : mag_acc;
            end
            parsed_replies.push_back(res);
            seen_cnt = '0;
            pfx_bad = 1'b0;
            neg_sign = 1'b0;
            got_digit = 1'b0;
            num_done = 1'b0;
            too_big = 1'b0;
            mag_acc = '0;
        end
    endtask

    // Character driver: offers the next queued character, with random gaps.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) parse_reply_char(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (char_queue.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
                    next_char = char_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_char.ch;
                    s_tlast <= next_char.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each result transfer with the oldest expected reply.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (parsed_replies.size() == 0) begin
                    $error("result transfer with no reply outstanding: status %0d value %0d",
                           m_tuser, $signed(m_tdata));
                    failures++;
                end else begin
                    got_reply = parsed_replies.pop_front();
                    if (m_tuser !== got_reply.status) begin
                        $error("status: expected %0d, got %0d", got_reply.status, m_tuser);
                        failures++;
                    end
                    if (m_tdata !== got_reply.value) begin
                        $error("value: expected %0d, got %0d",
                               $signed(got_reply.value), $signed(m_tdata));
                        failures++;
                    end
                end
            end
            m_tready <= calm || ($urandom_range(99) >= 16);
        end
    end

    // Watchdog on cycles in which neither side completes a transfer.
    always @(posedge i_clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet == QuietLimit) begin
                $display("** prefixed_decimal_reply_parser: FAILED **");
                $finish;
            end
        end
    end

    task automatic cfg_write(input pdrp_pkg::t_reg_index idx, input logic [ValueW-1:0] data);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == pdrp_pkg::REG_PREFIX_CHARS)
            pfx_chars = data;
        else
            pfx_len = data[CountW-1:0];
    endtask

    task automatic set_prefix(input logic [ValueW-1:0] chars, input logic [CountW-1:0] len);
        cfg_write(pdrp_pkg::REG_PREFIX_CHARS, chars);
        cfg_write(pdrp_pkg::REG_PREFIX_LENGTH, ValueW'(len));
    endtask

    // Wait until every character is sent and every reply checked, then let
    // the pipeline empty before the configuration is touched.
    task automatic settle();
        while (char_queue.size() != 0 || s_tvalid || parsed_replies.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) reply_buf.push_back(s[i]);
    endtask

    task automatic put_prefix();
        int i;
        for (i = 0; i < eff_pfx_len(); i++) reply_buf.push_back(pfx_chars[i*8 +: 8]);
    endtask

    // Move the reply being built into the send queue, marking its final character.
    task automatic end_reply();
        int i;
        t_char_item c;
        for (i = 0; i < reply_buf.size(); i++) begin
            c.ch = reply_buf[i];
            c.last = (i == reply_buf.size() - 1);
            char_queue.push_back(c);
        end
        gen_count += reply_buf.size();
        reply_buf.delete();
    endtask

    task automatic say(input string payload);
        put_prefix();
        put_text(payload);
        end_reply();
    endtask

    // Mostly well-formed replies with random numbers, plus short, corrupted
    // and noisy ones.
    task automatic random_reply();
        int plen;
        int pick;
        int n;
        int i;
        logic [ChW-1:0] b;
        plen = eff_pfx_len();
        pick = $urandom_range(99);
        if (plen > 0 && pick < 8) begin
            n = $urandom_range(plen, 1);
            for (i = 0; i < n; i++) reply_buf.push_back(pfx_chars[i*8 +: 8]);
            end_reply();
            return;
        end
        put_prefix();
        if (plen > 0 && pick < 16) begin
            i = $urandom_range(plen - 1);
            b = ChW'($urandom_range(255, 1));
            reply_buf[i] = reply_buf[i] ^ b;
        end
        pick = $urandom_range(99);
        if (pick < 10) begin
            n = $urandom_range(6, 1);
            repeat (n) begin
                b = ChW'($urandom_range(255));
                reply_buf.push_back(b);
            end
        end else begin
            if ($urandom_range(99) < 40) reply_buf.push_back(pdrp_pkg::ChMinus);
            if (pick < 15) begin
                b = ChW'($urandom_range(255));
                reply_buf.push_back(b);
            end else begin
                if (pick < 40) begin
                    // Walk right up to the edge of the 64-bit range.
                    put_text("922337203685477580");
                    n = $urandom_range(2, 0);
                end else begin
                    n = $urandom_range(21, 1);
                end
                repeat (n) begin
                    b = pdrp_pkg::ChZero + ChW'($urandom_range(9));
                    reply_buf.push_back(b);
                end
            end
            if ($urandom_range(99) < 15) begin
                n = $urandom_range(3, 1);
                repeat (n) begin
                    b = ChW'($urandom_range(255));
                    reply_buf.push_back(b);
                end
            end
        end
        end_reply();
    endtask

    initial begin
        int ph;
        logic [ValueW-1:0] chars;
        logic [CountW-1:0] len;
        gen_count = 0;
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;

        // Prefix length zero straight after reset: the whole reply is payload.
        say("0");
        say("-");
        say("-0");
        say("+1");
        say("-9223372036854775808");
        settle();

        // Three-character prefix: range edges, signs, trailing and short replies.
        set_prefix(64'h3D563F, 4'd3);
        say("123");
        say("9223372036854775807");
        say("9223372036854775808");
        say("-9223372036854775809");
        say("12a");
        say("99999999999999999999x");
        say("--5");
        say("5-");
        say(" 5");
        put_text("?V=");
        end_reply();
        put_text("?X=1");
        end_reply();
        put_prefix();
        put_text("7");
        reply_buf.push_back(8'hFF);
        end_reply();
        put_prefix();
        put_text("8");
        reply_buf.push_back(8'h00);
        end_reply();
        settle();

        // Full-width prefix holding byte extremes, then a mismatch on its last byte.
        set_prefix(64'hFF00_4180_7F2D_3900, pdrp_pkg::PrefixMax);
        say("-42");
        put_prefix();
        reply_buf[pdrp_pkg::PrefixMax - 1] = 8'hFE;
        put_text("1");
        end_reply();
        settle();

        // Oversized prefix length acts as the maximum.
        cfg_write(pdrp_pkg::REG_PREFIX_LENGTH, 64'd15);
        say("5");
        say("-");
        settle();

        // Random phases over a spread of prefix settings.
        for (ph = 0; ph < RandomPhases; ph++) begin
            case (ph)
                0: begin chars = '0;                      len = 4'd0;  end
                1: begin chars = 64'h3D563F;              len = 4'd3;  end
                2: begin chars = {$urandom, $urandom};    len = 4'd5;  end
                3: begin chars = '1;                      len = pdrp_pkg::PrefixMax; end
                4: begin chars = {$urandom, $urandom};    len = 4'd15; end
                5: begin chars = {$urandom, $urandom};    len = 4'd1;  end
                6: begin chars = {$urandom, $urandom};    len = 4'd7;  end
                default: begin chars = {$urandom, $urandom}; len = 4'd11; end
            endcase
            set_prefix(chars, len);
            // One phase runs with neither side pausing.
            calm <= (ph == 1);
            gen_count = 0;
            while (gen_count < PhaseChars) random_reply();
            settle();
        end

        repeat (8) @(posedge i_clk);
        if (failures == 0 && parsed_replies.size() == 0)
            $display("** prefixed_decimal_reply_parser: PASSED **");
        else
            $display("** prefixed_decimal_reply_parser: FAILED **");
        $finish;
    end

endmodule
